@@ rtl/conv3_pkg.sv @@
// ----------------------------------------------------------------------------
// conv3_pkg: shared types and constants for the 3x3 convolution engine
// Op codes, register indexes, default sizes and the MAC control group.
// ----------------------------------------------------------------------------
package conv3_pkg;

  // default sizes
  localparam int DEF_MAX_IN_CHANNELS  = 16;
  localparam int DEF_MAX_OUT_CHANNELS = 16;
  localparam int DEF_MAX_HEIGHT       = 32;
  localparam int DEF_MAX_WIDTH        = 32;
  localparam int DEF_FRAC_BITS        = 8;

  // kernel geometry
  localparam int KERNEL_TAPS = 9;

  // fixed field widths
  localparam int DATA_W   = 16;
  localparam int ADDR_W   = 14;
  localparam int FILT_W   = 4;
  localparam int POS_W    = 5;
  localparam int CHAN_W   = 5;
  localparam int DIM_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // op codes
  localparam logic [1:0] OP_LOAD_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] OP_LOAD_BIAS   = 2'd2;
  localparam logic [1:0] OP_COMPUTE     = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 2'd3;

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic init;    // load accumulator with the shifted bias
    logic mul_en;  // RAM data is a live tap: multiply and accumulate it
  } mac_ctrl_t;

endpackage

@@ rtl/conv3_ram.sv @@
// ----------------------------------------------------------------------------
// conv3_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module conv3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/conv3_mac.sv @@
// ----------------------------------------------------------------------------
// conv3_mac: shared multiply-accumulate unit
// Registered 16x16 product, wide accumulator, round-half-up and saturation.
// ----------------------------------------------------------------------------
module conv3_mac
  import conv3_pkg::*;
#(
  parameter int MAX_IN_CHANNELS = DEF_MAX_IN_CHANNELS,
  parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] bias,
  input  logic signed [DATA_W-1:0] sample,
  input  logic signed [DATA_W-1:0] weight,
  output logic signed [DATA_W-1:0] res_value,
  output logic                     res_sat
);

  localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_IN_CHANNELS * KERNEL_TAPS + 1) + 1;
  localparam int HALF_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic signed [ACC_W-1:0] HALF =
    (FRAC_BITS > 0) ? (ACC_W'(1) <<< HALF_SH) : '0;
  localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32'sd32767);
  localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32'sd32768);

  logic signed [2*DATA_W-1:0] prod;
  logic                       prod_v;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    rsum;
  logic signed [ACC_W-1:0]    rshift;
  logic                       sat_hi;
  logic                       sat_lo;

  always_ff @(posedge clk) begin
    prod <= sample * weight;
    if (ctrl.init) begin
      acc <= ACC_W'(bias) <<< FRAC_BITS;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctrl.mul_en;
    end
  end

  // add half, then floor
  assign rsum   = acc + HALF;
  assign rshift = rsum >>> FRAC_BITS;
  assign sat_hi = rshift > Q_MAX;
  assign sat_lo = rshift < Q_MIN;

  always_comb begin
    if (sat_hi) begin
      res_value = 16'sh7fff;
    end else if (sat_lo) begin
      res_value = 16'sh8000;
    end else begin
      res_value = rshift[DATA_W-1:0];
    end
  end

  assign res_sat = sat_hi || sat_lo;

endmodule

@@ rtl/conv3x3_same_padding_engine.sv @@
// ----------------------------------------------------------------------------
// conv3x3_same_padding_engine: multi-channel 3x3 convolution, stride 1, pad 1
// Loads fill image, weight and bias RAMs; a compute returns one output pixel.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start is high and busy is low. Loads
// (sample, weight, bias) give no result and leave busy low.
// A compute runs on one shared 16x16 multiplier, one tap per cycle (padding
// taps included) over the ci input channels, ci being in_channels clamped to
// MAX_IN_CHANNELS; busy stays high through the setup states, the taps, the
// drain state and the rounding state. The result strobe (result_valid) is
// high for exactly one cycle, the first cycle after busy falls. The receiver
// cannot stall it, so capture out_value/saturated/status when result_valid
// is high.
// An out-of-range compute (filter, row or column) returns status=1 with a
// zero value in the cycle after it is taken, without going busy. Stores hold
// garbage until written; reading an unwritten entry gives undefined data.
// Config writes are always accepted (cfg_ready is tied high) and must only
// be issued while the engine is idle.
// ----------------------------------------------------------------------------
module conv3x3_same_padding_engine
  import conv3_pkg::*;
#(
  parameter int MAX_IN_CHANNELS  = DEF_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = DEF_MAX_OUT_CHANNELS,
  parameter int MAX_HEIGHT       = DEF_MAX_HEIGHT,
  parameter int MAX_WIDTH        = DEF_MAX_WIDTH,
  parameter int FRAC_BITS        = DEF_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               op,
  input  logic [ADDR_W-1:0]        address,
  input  logic signed [DATA_W-1:0] value,
  input  logic [FILT_W-1:0]        filter_sel,
  input  logic [POS_W-1:0]         out_row,
  input  logic [POS_W-1:0]         out_col,
  // result channel
  output logic                     result_valid,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     saturated,
  output logic                     status,
  // configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  // store geometry
  localparam int IMG_DEPTH  = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int WGT_DEPTH  = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * KERNEL_TAPS;
  localparam int BIAS_DEPTH = MAX_OUT_CHANNELS;
  localparam int IMG_AW  = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
  localparam int WGT_AW  = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int BIAS_AW = (BIAS_DEPTH > 1) ? $clog2(BIAS_DEPTH) : 1;
  localparam int FCI_W   = FILT_W + CHAN_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP1 = 3'd1;  // address products, bias read
  localparam logic [2:0] S_SETUP2 = 3'd2;  // start addresses, acc <= bias
  localparam logic [2:0] S_RUN    = 3'd3;  // one tap read per cycle
  localparam logic [2:0] S_DRAIN  = 3'd4;  // let the MAC pipe empty
  localparam logic [2:0] S_ROUND  = 3'd5;  // capture rounded result

  logic [2:0] state;

  // configuration registers
  logic [CHAN_W-1:0] in_channels;
  logic [CHAN_W-1:0] out_channels;
  logic [DIM_W-1:0]  height;
  logic [DIM_W-1:0]  width;

  // clamped sizes
  logic [CHAN_W-1:0] ci;
  logic [CHAN_W-1:0] co;
  logic [DIM_W-1:0]  h;
  logic [DIM_W-1:0]  w;

  // compute target
  logic [FILT_W-1:0] tgt_filter;
  logic [POS_W-1:0]  tgt_row;
  logic [POS_W-1:0]  tgt_col;

  // address generation
  logic [IMG_AW-1:0] center;
  logic [IMG_AW-1:0] hw;
  logic [FCI_W-1:0]  fci;
  logic [IMG_AW-1:0] taddr;
  logic [IMG_AW-1:0] rowstart;
  logic [WGT_AW-1:0] waddr;
  logic [CHAN_W-1:0] ch;
  logic [1:0]        ky;
  logic [1:0]        kx;
  logic [1:0]        drain_cnt;
  logic              row_ok;
  logic              col_ok;
  logic              last_tap;

  // read pipeline
  logic rd_v;
  logic rd_ok;

  logic accept;
  logic range_err;

  logic signed [DATA_W-1:0] img_rdata;
  logic signed [DATA_W-1:0] wgt_rdata;
  logic signed [DATA_W-1:0] bias_rdata;
  logic signed [DATA_W-1:0] mac_value;
  logic                     mac_sat;
  mac_ctrl_t                mac_ctrl;

  logic img_we;
  logic wgt_we;
  logic bias_we;

  // --------------------------------------------------------------------------
  // clamp registers to the built sizes
  // --------------------------------------------------------------------------
  assign ci = (32'(in_channels) > MAX_IN_CHANNELS)  ? CHAN_W'(MAX_IN_CHANNELS)  : in_channels;
  assign co = (32'(out_channels) > MAX_OUT_CHANNELS) ? CHAN_W'(MAX_OUT_CHANNELS) : out_channels;
  assign h  = (32'(height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height;
  assign w  = (32'(width) > MAX_WIDTH)   ? DIM_W'(MAX_WIDTH)  : width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_channels  <= CHAN_W'(1);
      out_channels <= CHAN_W'(1);
      height       <= DIM_W'(32);
      width        <= DIM_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_CHANNELS:  in_channels  <= cfg_data[CHAN_W-1:0];
        REG_OUT_CHANNELS: out_channels <= cfg_data[CHAN_W-1:0];
        REG_HEIGHT:       height       <= cfg_data;
        REG_WIDTH:        width        <= cfg_data;
        default:          ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // command handshake
  // --------------------------------------------------------------------------
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign range_err = ({1'b0, filter_sel} >= co) ||
                     ({1'b0, out_row} >= h) ||
                     ({1'b0, out_col} >= w);

  // loads outside a store are dropped
  assign img_we  = accept && (op == OP_LOAD_SAMPLE) && (32'(address) < IMG_DEPTH);
  assign wgt_we  = accept && (op == OP_LOAD_WEIGHT) && (32'(address) < WGT_DEPTH);
  assign bias_we = accept && (op == OP_LOAD_BIAS)   && (32'(address) < BIAS_DEPTH);

  // --------------------------------------------------------------------------
  // tap bookkeeping: padding taps still step the addresses but skip the MAC
  // --------------------------------------------------------------------------
  assign row_ok = !(((ky == 2'd0) && (tgt_row == '0)) ||
                    ((ky == 2'd2) && (({1'b0, tgt_row} + DIM_W'(1)) >= h)));
  assign col_ok = !(((kx == 2'd0) && (tgt_col == '0)) ||
                    ((kx == 2'd2) && (({1'b0, tgt_col} + DIM_W'(1)) >= w)));
  assign last_tap = (ky == 2'd2) && (kx == 2'd2) &&
                    (({1'b0, ch} + (CHAN_W + 1)'(1)) == {1'b0, ci});

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      rd_v         <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_v         <= (state == S_RUN);
      case (state)
        S_IDLE: begin
          if (accept && (op == OP_COMPUTE)) begin
            if (range_err) begin
              // answered at once, no MAC pass
              result_valid <= 1'b1;
              out_value    <= '0;
              saturated    <= 1'b0;
              status       <= STATUS_RANGE;
            end else begin
              state <= S_SETUP1;
            end
          end
        end
        S_SETUP1: begin
          state <= S_SETUP2;
        end
        S_SETUP2: begin
          state <= (ci == '0) ? S_DRAIN : S_RUN;
        end
        S_RUN: begin
          if (last_tap) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == 2'd1) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          result_valid <= 1'b1;
          out_value    <= mac_value;
          saturated    <= mac_sat;
          status       <= STATUS_OK;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    rd_ok <= row_ok && col_ok;
    case (state)
      S_IDLE: begin
        tgt_filter <= filter_sel;
        tgt_row    <= out_row;
        tgt_col    <= out_col;
      end
      S_SETUP1: begin
        center <= IMG_AW'(tgt_row) * IMG_AW'(w) + IMG_AW'(tgt_col);
        hw     <= IMG_AW'(h) * IMG_AW'(w);
        fci    <= FCI_W'(tgt_filter) * FCI_W'(ci);
      end
      S_SETUP2: begin
        // top-left tap of channel 0; wraps mod 2^IMG_AW on the border,
        // but such taps are never counted
        taddr     <= center - IMG_AW'(w) - IMG_AW'(1);
        rowstart  <= center - IMG_AW'(w) - IMG_AW'(1);
        waddr     <= (WGT_AW'(fci) << 3) + WGT_AW'(fci);
        ch        <= '0;
        ky        <= '0;
        kx        <= '0;
        drain_cnt <= '0;
      end
      S_RUN: begin
        waddr <= waddr + WGT_AW'(1);  // weights of one filter are contiguous
        if (kx == 2'd2) begin
          kx <= '0;
          if (ky == 2'd2) begin
            ky       <= '0;
            ch       <= ch + CHAN_W'(1);
            rowstart <= rowstart + hw;
            taddr    <= rowstart + hw;
          end else begin
            ky    <= ky + 2'd1;
            taddr <= taddr + IMG_AW'(w) - IMG_AW'(2);
          end
        end else begin
          kx    <= kx + 2'd1;
          taddr <= taddr + IMG_AW'(1);
        end
      end
      S_DRAIN: begin
        drain_cnt <= drain_cnt + 2'd1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // stores
  // --------------------------------------------------------------------------
  conv3_ram #(
    .WIDTH (DATA_W),
    .DEPTH (IMG_DEPTH)
  ) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (IMG_AW'(address)),
    .wdata (value),
    .raddr (taddr),
    .rdata (img_rdata)
  );

  conv3_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (WGT_AW'(address)),
    .wdata (value),
    .raddr (waddr),
    .rdata (wgt_rdata)
  );

  conv3_ram #(
    .WIDTH (DATA_W),
    .DEPTH (BIAS_DEPTH)
  ) u_bias_ram (
    .clk   (clk),
    .we    (bias_we),
    .waddr (BIAS_AW'(address)),
    .wdata (value),
    .raddr (BIAS_AW'(tgt_filter)),
    .rdata (bias_rdata)
  );

  // --------------------------------------------------------------------------
  // shared MAC: bias read issued in SETUP1 lands in SETUP2
  // --------------------------------------------------------------------------
  assign mac_ctrl.init   = (state == S_SETUP2);
  assign mac_ctrl.mul_en = rd_v && rd_ok;

  conv3_mac #(
    .MAX_IN_CHANNELS (MAX_IN_CHANNELS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .bias      (bias_rdata),
    .sample    (img_rdata),
    .weight    (wgt_rdata),
    .res_value (mac_value),
    .res_sat   (mac_sat)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for conv3x3_same_padding_engine
// Drives load and compute transactions, keeps a shadow copy of the image,
// weight and bias RAMs plus the size registers, predicts every output pixel
// and compares each strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
  import conv3_pkg::*;

  // store depths at the default parameter set
  localparam int IMAGE_DEPTH  = DEF_MAX_IN_CHANNELS * DEF_MAX_HEIGHT * DEF_MAX_WIDTH;
  localparam int KERNEL_DEPTH = DEF_MAX_OUT_CHANNELS * DEF_MAX_IN_CHANNELS * KERNEL_TAPS;
  localparam int BIAS_DEPTH   = DEF_MAX_OUT_CHANNELS;
  localparam int KERNEL_SIDE  = 3;
  localparam int FRAC_BITS    = DEF_FRAC_BITS;

  // covers the longest compute (16 input channels) and the strobe after it
  localparam int SETTLE_CYCLES = KERNEL_TAPS * DEF_MAX_IN_CHANNELS + 8;
  // far above the slowest legal run, at the sparsest sender
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              stat;
  } pixel_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  start      = 1'b0;
  logic                  busy;
  logic [1:0]            op         = OP_LOAD_SAMPLE;
  logic [ADDR_W-1:0]     address    = '0;
  logic [DATA_W-1:0]     value      = '0;
  logic [FILT_W-1:0]     filter_sel = '0;
  logic [POS_W-1:0]      out_row    = '0;
  logic [POS_W-1:0]      out_col    = '0;
  logic                  result_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                  saturated;
  logic                  status;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_IN_CHANNELS;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  conv3x3_same_padding_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .address      (address),
    .value        (value),
    .filter_sel   (filter_sel),
    .out_row      (out_row),
    .out_col      (out_col),
    .result_valid (result_valid),
    .out_value    (out_value),
    .saturated    (saturated),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Shadow state. The *_set flags track which RAM entries hold defined data;
  // stimulus never lets a compute touch an entry that was not loaded first.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] image_mem  [IMAGE_DEPTH];
  logic [DATA_W-1:0] kernel_mem [KERNEL_DEPTH];
  logic [DATA_W-1:0] bias_mem   [BIAS_DEPTH];
  bit                image_set  [IMAGE_DEPTH];
  bit                kernel_set [KERNEL_DEPTH];
  bit                bias_set   [BIAS_DEPTH];

  // raw register contents, as written (masked to register width)
  int in_ch_cfg  = 1;
  int out_ch_cfg = 1;
  int height_cfg = DEF_MAX_HEIGHT;
  int width_cfg  = DEF_MAX_WIDTH;

  pixel_t pending_pixels[$];   // predicted results, oldest first
  int     error_count     = 0;
  int     sender_idle_pct = 0; // chance per cycle that the sender holds off
  int     items_sent      = 0; // accepted command transactions, loads included

  // registers above their maximum behave as the maximum
  function automatic int clamp_dim(int raw, int top);
    return (raw > top) ? top : raw;
  endfunction

  // sample/weight/bias values: a mix of full range, near-unity, extremes
  function automatic logic [DATA_W-1:0] rand_datum();
    case ($urandom_range(0, 3))
      0: return DATA_W'($urandom);
      1: return DATA_W'($urandom_range(0, 600) - 300);
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hFFFF;
        endcase
      end
      default: return DATA_W'($urandom_range(0, 8192) - 4096);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    error_count++;
  endtask

  // --------------------------------------------------------------------------
  // Send one command transaction. Taken at the edge where start is high and
  // busy is low; busy is read right after the edge, i.e. its pre-edge value.
  // On acceptance the shadow state is updated and, for a compute, the
  // expected pixel is queued.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] item_op, logic [ADDR_W-1:0] item_addr,
                           logic [DATA_W-1:0] item_value, logic [FILT_W-1:0] item_filt,
                           logic [POS_W-1:0] item_row, logic [POS_W-1:0] item_col);
    int     ci, co, h, w, ch, tap, yy, xx, idx;
    longint acc;
    pixel_t px;
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    op         <= item_op;
    address    <= item_addr;
    value      <= item_value;
    filter_sel <= item_filt;
    out_row    <= item_row;
    out_col    <= item_col;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;

    case (item_op)
      OP_LOAD_SAMPLE: begin
        if (item_addr < IMAGE_DEPTH) begin
          image_mem[item_addr] = item_value;
          image_set[item_addr] = 1'b1;
        end
      end
      OP_LOAD_WEIGHT: begin
        // weight addresses past the store are dropped
        if (item_addr < KERNEL_DEPTH) begin
          kernel_mem[item_addr] = item_value;
          kernel_set[item_addr] = 1'b1;
        end
      end
      OP_LOAD_BIAS: begin
        if (item_addr < BIAS_DEPTH) begin
          bias_mem[item_addr] = item_value;
          bias_set[item_addr] = 1'b1;
        end
      end
      default: begin
        ci = clamp_dim(in_ch_cfg, DEF_MAX_IN_CHANNELS);
        co = clamp_dim(out_ch_cfg, DEF_MAX_OUT_CHANNELS);
        h  = clamp_dim(height_cfg, DEF_MAX_HEIGHT);
        w  = clamp_dim(width_cfg, DEF_MAX_WIDTH);
        px.value = '0;
        px.sat   = 1'b0;
        px.stat  = STATUS_OK;
        if (int'(item_filt) >= co || int'(item_row) >= h || int'(item_col) >= w) begin
          // target off the image or filter unused: flagged, value zero
          px.stat = STATUS_RANGE;
        end else begin
          // bias aligned to the Q16 product scale
          acc = longint'($signed(bias_mem[item_filt])) * (longint'(1) << FRAC_BITS);
          for (ch = 0; ch < ci; ch++) begin
            for (tap = 0; tap < KERNEL_TAPS; tap++) begin
              yy = int'(item_row) + tap / KERNEL_SIDE - 1;
              xx = int'(item_col) + tap % KERNEL_SIDE - 1;
              // zero padding: taps off the image add nothing
              if (yy < 0 || xx < 0 || yy >= h || xx >= w) continue;
              idx = (ch * h + yy) * w + xx;
              acc += longint'($signed(image_mem[idx]))
                   * longint'($signed(kernel_mem[(int'(item_filt) * ci + ch) * KERNEL_TAPS
                                                 + tap]));
            end
          end
          // round half up, then floor back to Q8.8
          acc += longint'(1) << (FRAC_BITS - 1);
          acc = acc >>> FRAC_BITS;
          if (acc > 32767) begin
            acc    = 32767;
            px.sat = 1'b1;
          end else if (acc < -32768) begin
            acc    = -32768;
            px.sat = 1'b1;
          end
          px.value = acc[DATA_W-1:0];
        end
        pending_pixels.push_back(px);
      end
    endcase
  endtask

  // Load every entry a compute at (f, r, c) will read that still holds
  // undefined data: the bias, and the live taps of image and weights.
  task automatic prepare_pixel(int f, int r, int c);
    int ci, h, w, ch, tap, yy, xx, idx;
    ci = clamp_dim(in_ch_cfg, DEF_MAX_IN_CHANNELS);
    h  = clamp_dim(height_cfg, DEF_MAX_HEIGHT);
    w  = clamp_dim(width_cfg, DEF_MAX_WIDTH);
    if (!bias_set[f])
      send_item(OP_LOAD_BIAS, ADDR_W'(f), rand_datum(), FILT_W'($urandom),
                POS_W'($urandom), POS_W'($urandom));
    for (ch = 0; ch < ci; ch++) begin
      for (tap = 0; tap < KERNEL_TAPS; tap++) begin
        yy = r + tap / KERNEL_SIDE - 1;
        xx = c + tap % KERNEL_SIDE - 1;
        if (yy < 0 || xx < 0 || yy >= h || xx >= w) continue;
        idx = (ch * h + yy) * w + xx;
        if (!image_set[idx])
          send_item(OP_LOAD_SAMPLE, ADDR_W'(idx), rand_datum(), FILT_W'($urandom),
                    POS_W'($urandom), POS_W'($urandom));
        idx = (f * ci + ch) * KERNEL_TAPS + tap;
        if (!kernel_set[idx])
          send_item(OP_LOAD_WEIGHT, ADDR_W'(idx), rand_datum(), FILT_W'($urandom),
                    POS_W'($urandom), POS_W'($urandom));
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IN_CHANNELS:  in_ch_cfg  = int'(data[CHAN_W-1:0]);
      REG_OUT_CHANNELS: out_ch_cfg = int'(data[CHAN_W-1:0]);
      REG_HEIGHT:       height_cfg = int'(data[DIM_W-1:0]);
      default:          width_cfg  = int'(data[DIM_W-1:0]);
    endcase
  endtask

  // Size registers change only with the engine idle: drain all outstanding
  // pixels, give a compute that may still be in flight time to finish.
  task automatic configure(int ci, int co, int h, int w);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_IN_CHANNELS, CFG_DATA_W'(ci));
    write_reg(REG_OUT_CHANNELS, CFG_DATA_W'(co));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    cfg_valid <= 1'b0;
  endtask

  // One random transaction (plus any loads it needs first). Mostly computes
  // on valid targets with their data in place, then refreshes of live data,
  // stray computes anywhere in the field range, and loads to any address.
  task automatic random_item();
    int ci, co, h, w, pick;
    logic [FILT_W-1:0] f;
    logic [POS_W-1:0]  r, c;
    logic [1:0]        load_op;
    logic [ADDR_W-1:0] addr;
    ci = clamp_dim(in_ch_cfg, DEF_MAX_IN_CHANNELS);
    co = clamp_dim(out_ch_cfg, DEF_MAX_OUT_CHANNELS);
    h  = clamp_dim(height_cfg, DEF_MAX_HEIGHT);
    w  = clamp_dim(width_cfg, DEF_MAX_WIDTH);
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      if (pick < 60 && co > 0 && h > 0 && w > 0) begin
        f = FILT_W'($urandom_range(0, co - 1));
        r = POS_W'($urandom_range(0, h - 1));
        c = POS_W'($urandom_range(0, w - 1));
      end else begin
        f = FILT_W'($urandom);
        r = POS_W'($urandom);
        c = POS_W'($urandom);
      end
      if (int'(f) < co && int'(r) < h && int'(c) < w) prepare_pixel(int'(f), int'(r), int'(c));
      send_item(OP_COMPUTE, ADDR_W'($urandom), DATA_W'($urandom), f, r, c);
    end else begin
      load_op = 2'($urandom_range(0, 2));
      if (pick < 88) begin
        // overwrite something the current geometry actually uses
        case (load_op)
          OP_LOAD_SAMPLE:
            addr = ADDR_W'($urandom_range(0, (ci * h * w > 0) ? ci * h * w - 1 : 0));
          OP_LOAD_WEIGHT:
            addr = ADDR_W'($urandom_range(0, (co * ci > 0) ? co * ci * KERNEL_TAPS - 1 : 0));
          default:
            addr = ADDR_W'($urandom_range(0, BIAS_DEPTH - 1));
        endcase
      end else begin
        addr = ADDR_W'($urandom);
      end
      send_item(load_op, addr, rand_datum(), FILT_W'($urandom), POS_W'($urandom),
                POS_W'($urandom));
    end
  endtask

  // Random traffic in chunks of about 100 transactions (loads included), each
  // under a freshly drawn configuration; sizes stay small most of the time so
  // computes and fills stay short.
  task automatic run_random_block(int n_items);
    int base, chunk_base;
    base = items_sent;
    while (items_sent - base < n_items) begin
      configure(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8));
      chunk_base = items_sent;
      while (items_sent - chunk_base < 100 && items_sent - base < n_items) begin
        random_item();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset sizes (1 in, 1 out, 32x32): saturation both ways, range errors,
  // loads past the end of the weight and bias stores, far corner, bias-only sum.
  task automatic test_directed();
    int k;
    send_item(OP_LOAD_BIAS, 0, 16'h7FFF, 0, 0, 0);
    // the four live taps of pixel (0,0): image (0,0),(0,1),(1,0),(1,1)
    send_item(OP_LOAD_SAMPLE, 0, 16'h7FFF, 0, 0, 0);
    send_item(OP_LOAD_SAMPLE, 1, 16'h7FFF, 0, 0, 0);
    send_item(OP_LOAD_SAMPLE, ADDR_W'(DEF_MAX_WIDTH), 16'h7FFF, 0, 0, 0);
    send_item(OP_LOAD_SAMPLE, ADDR_W'(DEF_MAX_WIDTH + 1), 16'h7FFF, 0, 0, 0);
    for (k = 4; k < KERNEL_TAPS; k++)
      if (k != 6) send_item(OP_LOAD_WEIGHT, ADDR_W'(k), 16'h7FFF, 0, 0, 0);
    send_item(OP_COMPUTE, 0, 0, 0, 0, 0);            // clips high
    send_item(OP_LOAD_BIAS, 0, 16'h8000, '1, '1, '1);
    for (k = 4; k < KERNEL_TAPS; k++)
      if (k != 6) send_item(OP_LOAD_WEIGHT, ADDR_W'(k), 16'h8000, '1, '1, '1);
    send_item(OP_COMPUTE, '1, '1, 0, 0, 0);          // clips low
    send_item(OP_COMPUTE, 0, 0, '1, 0, 0);           // filter beyond out_channels
    // writes past the weight and bias stores must be dropped
    send_item(OP_LOAD_WEIGHT, '1, 16'h1234, 0, 0, 0);
    send_item(OP_LOAD_BIAS, '1, 16'h4321, 0, 0, 0);
    send_item(OP_LOAD_SAMPLE, '1, 16'h5A5A, 0, 0, 0);
    prepare_pixel(0, DEF_MAX_HEIGHT - 1, DEF_MAX_WIDTH - 1);
    send_item(OP_COMPUTE, 0, 0, 0, '1, '1);          // bottom-right corner
    // no input channels: result is the bias alone
    configure(0, 1, 8, 8);
    send_item(OP_COMPUTE, 0, 0, 0, 7, 7);
    send_item(OP_COMPUTE, 0, 0, 0, 8, 0);            // row past height
    send_item(OP_COMPUTE, 0, 0, 0, 0, 8);            // column past width
  endtask

  // Register extremes: zero, one, maximum, and above maximum (clamped).
  // Each set gets up to 25 random items, cut short after about 40
  // transactions so the large sets do not flood the run with loads.
  task automatic test_register_extremes();
    int sets [11][4] = '{
      '{0, 1, 4, 4},     // bias only
      '{31, 2, 3, 3},    // in_channels clamps to 16
      '{2, 0, 4, 4},     // no filters: all range errors
      '{1, 31, 5, 5},    // out_channels clamps to 16
      '{1, 2, 0, 5},     // zero height
      '{1, 2, 5, 0},     // zero width
      '{1, 1, 63, 63},   // clamps to 32x32
      '{2, 3, 1, 1},     // single pixel
      '{3, 2, 1, 32},    // one row
      '{3, 2, 32, 1},    // one column
      '{16, 16, 32, 32}  // full size
    };
    int k, n, base;
    for (k = 0; k < 11; k++) begin
      configure(sets[k][0], sets[k][1], sets[k][2], sets[k][3]);
      base = items_sent;
      for (n = 0; n < 25 && items_sent - base < 40; n++) random_item();
    end
  endtask

  task automatic test_back_to_back();
    sender_idle_pct = 0;
    run_random_block(350);
  endtask

  task automatic test_sparse_sender();
    sender_idle_pct = 80;
    run_random_block(200);
  endtask

  task automatic test_mixed_idle();
    sender_idle_pct = 36;
    run_random_block(350);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: a result is taken at the edge that ends its strobe cycle,
  // so the outputs are read right at that edge, before they update.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && result_valid) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result with no compute outstanding (value %0d)",
                                  out_value));
      end else begin
        want = pending_pixels.pop_front();
        if (out_value !== want.value)
          report_mismatch($sformatf("out_value got %0d want %0d",
                                    out_value, $signed(want.value)));
        if (saturated !== want.sat)
          report_mismatch($sformatf("saturated got %b want %b", saturated, want.sat));
        if (status !== want.stat)
          report_mismatch($sformatf("status got %b want %b", status, want.stat));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_back_to_back();
    test_sparse_sender();
    test_mixed_idle();

    // drain, then allow one full compute time for any stray result
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
